@@ src/icm_pkg.sv @@
// Shared types, constants and table functions of the iteration count color map.
package icm_pkg;

  // Field and datapath widths.
  localparam int unsigned COUNT_W           = 11;
  localparam int unsigned MAX_W             = 16;
  localparam int unsigned MAX_COUNT_DEFAULT = 1024;
  localparam int unsigned T_W               = 16;
  localparam int unsigned RECIP_T_W         = T_W + COUNT_W;
  localparam int unsigned W_W               = 25;
  localparam int unsigned D_W               = 23;
  localparam int unsigned N_W               = 42;
  localparam int unsigned P_W               = 23;
  localparam int unsigned DIV_SHIFT         = 23;
  localparam int unsigned REC_W             = 14;
  localparam int unsigned DV_W              = 14;
  localparam int unsigned COEF_B_W          = 18;
  localparam int unsigned QE_W              = 14;
  localparam int unsigned NUM_STAGES        = 7;
  localparam int unsigned NUM_CHAN          = 3;

  // Start of each spectral band after violet, in Q.16 nanometers above 400 nm.
  localparam logic [W_W-1:0] BLUE_START   = W_W'(10 * 65536);
  localparam logic [W_W-1:0] GREEN_START  = W_W'(75 * 65536);
  localparam logic [W_W-1:0] YELLOW_START = W_W'(190 * 65536);
  localparam logic [W_W-1:0] RED_START    = W_W'(250 * 65536);

  // Reciprocals of the band divisors (100 times the band length), scaled by 2^DIV_SHIFT.
  localparam int unsigned REC_LEN10  = (1 << DIV_SHIFT) / 1000;
  localparam int unsigned REC_LEN65  = (1 << DIV_SHIFT) / 6500;
  localparam int unsigned REC_LEN115 = (1 << DIV_SHIFT) / 11500;
  localparam int unsigned REC_LEN60  = (1 << DIV_SHIFT) / 6000;
  localparam int unsigned REC_LEN50  = (1 << DIV_SHIFT) / 5000;

  // Palette register codes; the unused code falls back to the spectral palette.
  typedef enum logic [1:0] {
    PalSpectral = 2'd0,
    PalPink     = 2'd1,
    PalBlue     = 2'd2
  } palette_e;

  // Spectral bands.
  typedef enum logic [2:0] {
    SegViolet = 3'd0,
    SegBlue   = 3'd1,
    SegGreen  = 3'd2,
    SegYellow = 3'd3,
    SegRed    = 3'd4
  } spec_seg_e;

  // Color channels.
  typedef enum logic [1:0] {
    ChRed   = 2'd0,
    ChGreen = 2'd1,
    ChBlue  = 2'd2
  } chan_e;

  // Per band and channel: offset a, slope b, divisor dv and its reciprocal rec.
  typedef struct packed {
    logic signed [N_W-1:0]      a;
    logic signed [COEF_B_W-1:0] b;
    logic [DV_W-1:0]            dv;
    logic [REC_W-1:0]           rec;
  } seg_coef_t;

  // Builds one table entry from percent coefficients and the band length.
  function automatic seg_coef_t mk_coef(input int c0, input int c1, input int len,
                                        input int unsigned rec);
    seg_coef_t c;
    c.a   = N_W'(longint'(255) * longint'(c0) * longint'(len) * longint'(65536));
    c.b   = COEF_B_W'(255 * c1);
    c.dv  = DV_W'(100 * len);
    c.rec = REC_W'(rec);
    return c;
  endfunction

  // Piecewise-linear coefficients of the spectral palette.
  function automatic seg_coef_t seg_coef(input spec_seg_e seg, input chan_e ch);
    seg_coef_t c;
    c = mk_coef(0, 0, 10, REC_LEN10);
    unique case (seg)
      SegViolet: begin
        unique case (ch)
          ChRed:   c = mk_coef(0, 33, 10, REC_LEN10);
          ChBlue:  c = mk_coef(100, 0, 10, REC_LEN10);
          default: c = mk_coef(0, 0, 10, REC_LEN10);
        endcase
      end
      SegBlue: begin
        unique case (ch)
          ChRed:   c = mk_coef(14, -13, 65, REC_LEN65);
          ChGreen: c = mk_coef(0, 80, 65, REC_LEN65);
          default: c = mk_coef(100, 0, 65, REC_LEN65);
        endcase
      end
      SegGreen: begin
        unique case (ch)
          ChGreen: c = mk_coef(80, 76, 115, REC_LEN115);
          ChBlue:  c = mk_coef(100, -100, 115, REC_LEN115);
          default: c = mk_coef(0, 0, 115, REC_LEN115);
        endcase
      end
      SegYellow: begin
        unique case (ch)
          ChRed:   c = mk_coef(0, 198, 60, REC_LEN60);
          ChGreen: c = mk_coef(98, -6, 60, REC_LEN60);
          default: c = mk_coef(0, 0, 60, REC_LEN60);
        endcase
      end
      default: begin
        unique case (ch)
          ChRed:   c = mk_coef(65, -84, 50, REC_LEN50);
          default: c = mk_coef(0, 0, 50, REC_LEN50);
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

@@ src/icm_norm.sv @@
// Three-stage normalizer: iteration count to unsigned Q0.16 fraction of the maximum.
module icm_norm #(
  parameter int unsigned MAX_COUNT = icm_pkg::MAX_COUNT_DEFAULT
) (
  input  logic                        clk_i,
  input  logic [2:0]                  en_i,
  input  logic [icm_pkg::COUNT_W-1:0] count_i,
  output logic [icm_pkg::T_W-1:0]     t16_o
);
  import icm_pkg::*;

  localparam int unsigned PROD_W = COUNT_W + RECIP_T_W;
  localparam int unsigned CHK_W  = T_W + MAX_W + 1;
  localparam int unsigned NUM_W  = COUNT_W + T_W;
  localparam int unsigned RecipT = (1 << RECIP_T_W) / MAX_COUNT;
  localparam logic [RECIP_T_W-1:0] RecipV = RECIP_T_W'(RecipT);
  localparam logic [MAX_W-1:0]     MaxV   = MAX_W'(MAX_COUNT);

  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [COUNT_W-1:0] count0_q, count1_q;
  logic [T_W-1:0]     qe_d, qe_q;
  logic [T_W:0]       qe_inc;
  logic [CHK_W-1:0]   chk_d, chk_q;
  logic [NUM_W-1:0]   num;
  logic [T_W-1:0]     t16_d, t16_q;

  // Estimate the quotient by a reciprocal; it comes out exact or one low.
  assign prod_d = PROD_W'(count_i) * PROD_W'(RecipV);
  assign qe_d   = prod_q[COUNT_W +: T_W];
  assign qe_inc = {1'b0, qe_d} + (T_W+1)'(1);

  // Check whether the next quotient still fits under count * 2^16.
  assign chk_d  = CHK_W'(qe_inc) * CHK_W'(MaxV);
  assign num    = {count1_q, T_W'(0)};
  assign t16_d  = qe_q + T_W'(chk_q <= CHK_W'(num));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q   <= prod_d;
      count0_q <= count_i;
    end
    if (en_i[1]) begin
      qe_q     <= qe_d;
      chk_q    <= chk_d;
      count1_q <= count0_q;
    end
    if (en_i[2]) begin
      t16_q    <= t16_d;
    end
  end

  assign t16_o = t16_q;

endmodule

@@ src/icm_spec.sv @@
// Spectral palette pipeline: band select, linear segment, divide by band length, saturate.
module icm_spec (
  input  logic                    clk_i,
  input  logic [2:0]              en_i,
  input  logic [icm_pkg::T_W-1:0] t16_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);
  import icm_pkg::*;

  localparam int unsigned PROD_W = P_W + REC_W;
  localparam int unsigned CHK_W  = QE_W + 1 + DV_W;

  logic [W_W-1:0] w;
  spec_seg_e      seg_d, seg0_q, seg1_q, seg2_q;
  logic [D_W-1:0] d_d, d_q;
  logic [7:0]     chan_byte [NUM_CHAN];

  // Wavelength offset and the band that it falls in.
  always_comb begin
    w = W_W'(t16_i) * W_W'(300);
    if (w < BLUE_START) begin
      seg_d = SegViolet;
      d_d   = D_W'(w);
    end else if (w < GREEN_START) begin
      seg_d = SegBlue;
      d_d   = D_W'(w - BLUE_START);
    end else if (w < YELLOW_START) begin
      seg_d = SegGreen;
      d_d   = D_W'(w - GREEN_START);
    end else if (w < RED_START) begin
      seg_d = SegYellow;
      d_d   = D_W'(w - YELLOW_START);
    end else begin
      seg_d = SegRed;
      d_d   = D_W'(w - RED_START);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      seg0_q <= seg_d;
      d_q    <= d_d;
    end
    if (en_i[1]) begin
      seg1_q <= seg0_q;
    end
    if (en_i[2]) begin
      seg2_q <= seg1_q;
    end
  end

  // One lane per channel.
  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    seg_coef_t             coef1, coef2, coef3;
    logic signed [N_W-1:0] n_d;
    logic [P_W-1:0]        p1_q, p2_q;
    logic                  neg1_q, neg2_q;
    logic [PROD_W-1:0]     prod;
    logic [QE_W-1:0]       qe_q;
    logic [QE_W:0]         qe_inc, q;
    logic [CHK_W-1:0]      chk;

    // Linear value of the segment, scaled by 255, the band length and 2^16.
    always_comb begin
      coef1 = seg_coef(seg0_q, chan_e'(2'(ch)));
      n_d   = coef1.a + coef1.b * $signed({1'b0, d_q});
    end

    // Quotient estimate by the band's reciprocal.
    always_comb begin
      coef2 = seg_coef(seg1_q, chan_e'(2'(ch)));
      prod  = PROD_W'(p1_q) * PROD_W'(coef2.rec);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        p1_q   <= n_d[16 +: P_W];
        neg1_q <= n_d[N_W-1];
      end
      if (en_i[2]) begin
        p2_q   <= p1_q;
        neg2_q <= neg1_q;
        qe_q   <= prod[DIV_SHIFT +: QE_W];
      end
    end

    // Correct the estimate by one and saturate to a byte.
    always_comb begin
      coef3  = seg_coef(seg2_q, chan_e'(2'(ch)));
      qe_inc = {1'b0, qe_q} + (QE_W+1)'(1);
      chk    = CHK_W'(qe_inc) * CHK_W'(coef3.dv);
      q      = (chk <= CHK_W'(p2_q)) ? qe_inc : {1'b0, qe_q};
      if (neg2_q) begin
        chan_byte[ch] = 8'd0;
      end else if (q > (QE_W+1)'(255)) begin
        chan_byte[ch] = 8'd255;
      end else begin
        chan_byte[ch] = q[7:0];
      end
    end
  end

  assign red_o   = chan_byte[ChRed];
  assign green_o = chan_byte[ChGreen];
  assign blue_o  = chan_byte[ChBlue];

endmodule

@@ src/iteration_count_color_map.sv @@
// Top level of the iteration count color map: handshake, stage control and palette select.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   iteration_count_i
//   output    out        out_valid_o / out_stall_i red_o, green_o, blue_o, in_set_o
//   config    in         cfg_we_i                  cfg_data_i (palette mode)
//
// One word is accepted per clock while in_stall_o is low.
// The seven stages are: reciprocal multiply, quotient check, fraction, band select,
// segment multiply, divide by band length, and correction plus palette select.
// Reset clears the stage valid bits and sets the palette to spectral.
// A stalled output word holds; a stage loads whenever it is empty or its successor
// loads, so bubbles close up and the input stalls only when all stages are full.
module iteration_count_color_map #(
  parameter int unsigned MAX_COUNT = icm_pkg::MAX_COUNT_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [icm_pkg::COUNT_W-1:0] iteration_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic                        in_set_o
);
  import icm_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  localparam int unsigned LAST = NUM_STAGES - 1;
  localparam int unsigned HALF = 1 << (T_W - 1);

  logic [1:0]            palette_mode_q;
  logic [NUM_STAGES-1:0] en, v_q;
  logic [LAST-1:0]       set_q;
  logic [T_W-1:0]        t16_norm, t3_q, t4_q, t5_q;
  logic [7:0]            spec_r, spec_g, spec_b;
  logic [T_W+8:0]        pink_r, pink_b, blue_lo, blue_hi, blue_fade;
  pix_t                  pix_d, pix_q;
  logic                  in_set_q;

  // Palette mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_mode_q <= PalSpectral;
    end else if (cfg_we_i) begin
      palette_mode_q <= cfg_data_i;
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[LAST] = !v_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[LAST];

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Points of the set are flagged at entry and carried along.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      set_q[0] <= MAX_W'(iteration_count_i) >= MAX_W'(MAX_COUNT);
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        set_q[k] <= set_q[k-1];
      end
    end
  end

  icm_norm #(
    .MAX_COUNT (MAX_COUNT)
  ) u_norm (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .count_i (iteration_count_i),
    .t16_o   (t16_norm)
  );

  icm_spec u_spec (
    .clk_i   (clk_i),
    .en_i    (en[5:3]),
    .t16_i   (t16_norm),
    .red_o   (spec_r),
    .green_o (spec_g),
    .blue_o  (spec_b)
  );

  // The fraction rides alongside the spectral lanes for the simple palettes.
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      t3_q <= t16_norm;
    end
    if (en[4]) begin
      t4_q <= t3_q;
    end
    if (en[5]) begin
      t5_q <= t4_q;
    end
  end

  // Pink and blue palettes are piecewise-linear scalings of the fraction.
  assign pink_r    = (T_W+9)'(t5_q) * (T_W+9)'(255);
  assign pink_b    = (T_W+9)'(t5_q) * (T_W+9)'(192);
  assign blue_lo   = (T_W+9)'(t5_q) * (T_W+9)'(510);
  assign blue_hi   = (T_W+9)'(t5_q - T_W'(HALF)) * (T_W+9)'(510);
  assign blue_fade = ((T_W+9)'(1) << T_W) - (T_W+9)'(t5_q);

  // Palette select and the black override for points of the set.
  always_comb begin
    logic [T_W+8:0] fade;
    fade  = blue_fade * (T_W+9)'(255);
    pix_d = '0;
    case (palette_mode_q)
      PalPink: begin
        pix_d.r = pink_r[T_W +: 8];
        pix_d.b = pink_b[T_W +: 8];
      end
      PalBlue: begin
        if (t5_q < T_W'(HALF)) begin
          pix_d.b = blue_lo[T_W +: 8];
        end else begin
          pix_d.r = blue_hi[T_W +: 8];
          pix_d.g = blue_hi[T_W +: 8];
          pix_d.b = fade[T_W +: 8];
        end
      end
      default: begin
        pix_d.r = spec_r;
        pix_d.g = spec_g;
        pix_d.b = spec_b;
      end
    endcase
    if (set_q[LAST-1]) begin
      pix_d = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      pix_q    <= pix_d;
      in_set_q <= set_q[LAST-1];
    end
  end

  assign red_o    = pix_q.r;
  assign green_o  = pix_q.g;
  assign blue_o   = pix_q.b;
  assign in_set_o = in_set_q;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the iteration count color map.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icm_pkg::*;

  localparam int unsigned MAX_CNT    = MAX_COUNT_DEFAULT;
  localparam longint      UNIT_Q16   = 65536;
  localparam longint      HALF_Q16   = 32768;
  // The fourth register code has no palette of its own.
  localparam logic [1:0]  PAL_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_set;
  } pixel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [COUNT_W-1:0] iteration_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic               in_set_o;

  // Expected pixels in order of acceptance, and the palette the bench believes is set.
  pixel_t     pending_pixels[$];
  logic [1:0] palette_q;
  int         mismatch_count;
  bit         steady;

  iteration_count_color_map #(
    .MAX_COUNT(MAX_CNT)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .iteration_count_i(iteration_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .in_set_o         (in_set_o)
  );

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Clamps a channel value to a byte.
  function automatic logic [7:0] clamp_byte(input longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // One channel of a spectral band: floor(255 * (c0 + c1 * f) / 100), f = d / len.
  function automatic logic [7:0] band_level(input longint c0, input longint c1,
                                            input longint d, input longint len);
    longint den;
    longint num;
    den = 100 * len * UNIT_Q16;
    num = 255 * (c0 * len * UNIT_Q16 + c1 * d);
    if (num < 0) return 8'd0;
    return clamp_byte(num / den);
  endfunction

  // Expected pixel for one iteration count under the given palette.
  function automatic pixel_t predict_pixel(input logic [COUNT_W-1:0] count,
                                           input logic [1:0] mode);
    pixel_t px;
    longint t16;
    longint w;
    longint d;
    px = '0;
    if (count >= MAX_CNT) begin
      px.in_set = 1'b1;
    end else begin
      t16 = (longint'(count) * UNIT_Q16) / MAX_CNT;
      case (mode)
        PalPink: begin
          px.red  = clamp_byte((255 * t16) >>> 16);
          px.blue = clamp_byte((192 * t16) >>> 16);
        end
        PalBlue: begin
          if (t16 < HALF_Q16) begin
            px.blue = clamp_byte((510 * t16) >>> 16);
          end else begin
            px.red   = clamp_byte((510 * (t16 - HALF_Q16)) >>> 16);
            px.green = px.red;
            px.blue  = clamp_byte((255 * (UNIT_Q16 - t16)) >>> 16);
          end
        end
        default: begin
          // Spectral palette: wavelength offset in Q.16 nm, five linear bands.
          w = 300 * t16;
          if (w < 10 * UNIT_Q16) begin
            px.red  = band_level(0, 33, w, 10);
            px.blue = 8'd255;
          end else if (w < 75 * UNIT_Q16) begin
            d        = w - 10 * UNIT_Q16;
            px.red   = band_level(14, -13, d, 65);
            px.green = band_level(0, 80, d, 65);
            px.blue  = 8'd255;
          end else if (w < 190 * UNIT_Q16) begin
            d        = w - 75 * UNIT_Q16;
            px.green = band_level(80, 76, d, 115);
            px.blue  = band_level(100, -100, d, 115);
          end else if (w < 250 * UNIT_Q16) begin
            d        = w - 190 * UNIT_Q16;
            px.red   = band_level(0, 198, d, 60);
            px.green = band_level(98, -6, d, 60);
          end else begin
            d      = w - 250 * UNIT_Q16;
            px.red = band_level(65, -84, d, 50);
          end
        end
      endcase
    end
    return px;
  endfunction

  // Sends one count after a random gap (none in steady phases) and records its expected pixel on acceptance.
  task automatic send_count(input logic [COUNT_W-1:0] count);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    iteration_count_i <= count;
    do @(posedge clk_i); while (in_stall_o);
    pending_pixels.push_back(predict_pixel(count, palette_q));
  endtask

  // Stops sending and waits until every expected pixel has come out.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Writes the palette register while the block is idle.
  task automatic set_palette(input logic [1:0] mode);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    palette_q = mode;
  endtask

  // Random count, mostly below the maximum, sometimes at or above it.
  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(0, 15) == 0) return COUNT_W'($urandom_range(MAX_CNT, 2047));
    return COUNT_W'($urandom_range(0, MAX_CNT - 1));
  endfunction

  // Spectral palette straight out of reset: band edges, peaks and the set.
  task automatic test_reset_palette();
    send_count(11'd0);
    send_count(11'd34);
    send_count(11'd35);
    send_count(11'd255);
    send_count(11'd256);
    send_count(11'd648);
    send_count(11'd649);
    send_count(11'd700);
    send_count(11'd853);
    send_count(11'd854);
    send_count(11'd1023);
    send_count(11'd1024);
    send_count(11'd2047);
  endtask

  // Pink palette at both ends and the middle.
  task automatic test_pink_palette();
    set_palette(PalPink);
    send_count(11'd0);
    send_count(11'd512);
    send_count(11'd1023);
    send_count(11'd1024);
  endtask

  // Blue palette on either side of its half point.
  task automatic test_blue_palette();
    set_palette(PalBlue);
    send_count(11'd1);
    send_count(11'd511);
    send_count(11'd512);
    send_count(11'd1023);
  endtask

  // The unused code must behave as the spectral palette.
  task automatic test_unused_code();
    set_palette(PAL_UNUSED);
    send_count(11'd256);
    send_count(11'd1025);
  endtask

  // Random counts over several palette settings, some phases without idling.
  task automatic test_random_traffic();
    logic [1:0] mode;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 4) mode = 2'(phase);
      else mode = 2'($urandom_range(0, 3));
      set_palette(mode);
      steady = (phase == 2) || (phase == 5);
      for (int n = 0; n < 90; n++) send_count(random_count());
    end
    steady = 1'b0;
  endtask

  // Sender pauses mid-stream until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++) send_count(random_count());
    drain_pipeline();
    for (int n = 0; n < 30; n++) send_count(random_count());
  endtask

  // Receiver: random stall before each word, none during steady phases.
  initial begin
    int gap;
    out_stall_i = 1'b0;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted output word with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with no pixel expected");
        mismatch_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (red_o !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, red_o);
          mismatch_count++;
        end
        if (green_o !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, green_o);
          mismatch_count++;
        end
        if (blue_o !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, blue_o);
          mismatch_count++;
        end
        if (in_set_o !== exp_px.in_set) begin
          $error("in_set: expected %0d, got %0d", exp_px.in_set, in_set_o);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, then each test in turn, then the final verdict.
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    iteration_count_i = '0;
    palette_q         = PalSpectral;
    mismatch_count    = 0;
    steady            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_palette();
    test_pink_palette();
    test_blue_palette();
    test_unused_code();
    test_random_traffic();
    test_drain_pause();
    set_palette(PalSpectral);

    drain_pipeline();
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #200us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
src/icm_pkg.sv
src/icm_norm.sv
src/icm_spec.sv
src/iteration_count_color_map.sv
bench/tb_top.sv
